>>> design/mono_downmix_highpass_pcm16_core_macros.svh
// Assertion macros shared by the mono downmix high-pass core.
`ifndef MONO_DOWNMIX_HIGHPASS_PCM16_CORE_MACROS_SVH
`define MONO_DOWNMIX_HIGHPASS_PCM16_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MDHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MDHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mdhp_pkg.sv
// Shared types, constants and codes for the mono downmix high-pass core.
`default_nettype none
package mdhp_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int NUM_LANES    = 2;
  localparam int MAX_CHANNELS = 2;
  localparam int CH_CNT_W     = 2;
  localparam int GAIN_W       = 16;
  localparam int ALPHA_W      = 16;
  localparam int PCM_W        = 16;
  localparam int MIX_W        = SAMPLE_W + 1;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CH_CNT_W-1:0] CH_CNT_RESET  = CH_CNT_W'(1);
  localparam logic [GAIN_W-1:0]   GAIN_RESET    = GAIN_W'(4096);
  localparam logic                HPF_EN_RESET  = 1'b1;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET   = ALPHA_W'(64772);
  localparam logic signed [PCM_W-1:0] PCM_SCALE = 16'sd32767;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HPF_ENABLE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HPF_ALPHA     = CFG_IDX_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PCM_W-1:0]    pcm_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_GAIN,
    ST_FILT,
    ST_ALPHA,
    ST_SCALE,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic clear;
    logic gain;
    logic filt;
    logic alpha;
    logic scale;
  } ctrl_t;

endpackage
`default_nettype wire

>>> design/mdhp_lane.sv
// One channel lane: captures its sample, or zero when the channel is inactive.
`default_nettype none
module mdhp_lane (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              active,
  input  wire mdhp_pkg::sample_t sample,
  output mdhp_pkg::sample_t      lane_q
);
  import mdhp_pkg::*;

  sample_t lane_r;

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= active ? sample : '0;
    end
  end

  assign lane_q = lane_r;

endmodule
`default_nettype wire

>>> design/mdhp_merge.sv
// Merge stage: sums the lane samples and halves the sum for a stereo frame.
`default_nettype none
module mdhp_merge (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              two_ch,
  input  wire mdhp_pkg::sample_t lanes [mdhp_pkg::NUM_LANES],
  output mdhp_pkg::sample_t      mono
);
  import mdhp_pkg::*;

  logic signed [MIX_W-1:0] sum;
  logic signed [MIX_W-1:0] halved;
  sample_t                 mono_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = sum + MIX_W'(lanes[i]);
    end
    halved = sum >>> 1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mono_r <= two_ch ? halved[SAMPLE_W-1:0] : sum[SAMPLE_W-1:0];
    end
  end

  assign mono = mono_r;

endmodule
`default_nettype wire

>>> design/mdhp_filter.sv
// Gain, one-pole high-pass filter with its history, and PCM scaling.
`default_nettype none
module mdhp_filter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mdhp_pkg::ctrl_t                  ctrl,
  input  wire logic                             hpf_en,
  input  wire logic [mdhp_pkg::GAIN_W-1:0]      gain,
  input  wire logic [mdhp_pkg::ALPHA_W-1:0]     alpha,
  input  wire mdhp_pkg::sample_t                mono,
  output mdhp_pkg::pcm_t                        pcm
);
  import mdhp_pkg::*;

  localparam int M_W     = SAMPLE_W + 4;
  localparam int GPROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int APROD_W = 32 + ALPHA_W + 1;
  localparam int CLAMP_W = SAMPLE_W + 1;
  localparam int PPROD_W = CLAMP_W + PCM_W;

  localparam logic signed [31:0]      ONE_Q23  = 32'sd8388608;
  localparam logic signed [31:0]      NEG_ONE  = -32'sd8388608;
  localparam logic signed [33:0]      S32_MAX  = 34'sd2147483647;
  localparam logic signed [33:0]      S32_MIN  = -34'sd2147483648;

  logic signed [M_W-1:0]     m_r;
  logic signed [M_W-1:0]     pin_r;
  logic signed [31:0]        pout_r;
  logic signed [31:0]        s_r;
  logic signed [31:0]        v_r;
  logic signed [PPROD_W-1:0] pprod_r;

  logic signed [GPROD_W-1:0] gprod;
  logic signed [GPROD_W-1:0] grnd;
  logic signed [33:0]        fsum;
  logic signed [31:0]        fsat;
  logic signed [APROD_W-1:0] aprod;
  logic signed [APROD_W-1:0] arnd;
  logic signed [CLAMP_W-1:0] vclamp;
  logic signed [PPROD_W-1:0] pprod;
  logic signed [PPROD_W-1:0] prnd;

  always_comb begin
    gprod = mono * $signed({1'b0, gain});
    grnd  = gprod + GPROD_W'(2048);
    fsum  = 34'(pout_r) + 34'(m_r) - 34'(pin_r);
    if (fsum > S32_MAX) begin
      fsat = 32'sh7fffffff;
    end else if (fsum < S32_MIN) begin
      fsat = 32'sh80000000;
    end else begin
      fsat = fsum[31:0];
    end
    aprod = s_r * $signed({1'b0, alpha});
    arnd  = aprod + APROD_W'(32768);
    if (v_r > ONE_Q23) begin
      vclamp = ONE_Q23[CLAMP_W-1:0];
    end else if (v_r < NEG_ONE) begin
      vclamp = NEG_ONE[CLAMP_W-1:0];
    end else begin
      vclamp = v_r[CLAMP_W-1:0];
    end
    pprod = vclamp * PCM_SCALE;
    prnd  = pprod_r + PPROD_W'(4194304);
  end

  // Filter history: cleared at reset and by the start flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r  <= '0;
      pout_r <= '0;
    end else if (ctrl.clear) begin
      pin_r  <= '0;
      pout_r <= '0;
    end else if (ctrl.alpha) begin
      pin_r  <= m_r;
      // alpha below 1.0 keeps the rounded product inside 32 bits
      pout_r <= arnd[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.gain) begin
      m_r <= grnd[M_W+11:12];
    end
    if (ctrl.filt) begin
      if (hpf_en) begin
        s_r <= fsat;
      end else begin
        v_r <= 32'(m_r);
      end
    end
    if (ctrl.alpha) begin
      v_r <= arnd[47:16];
    end
    if (ctrl.scale) begin
      pprod_r <= pprod;
    end
  end

  assign pcm = prnd[PCM_W+22:23];

endmodule
`default_nettype wire

>>> design/mono_downmix_highpass_pcm16_core.sv
// Top level: configuration, sequencer, channel lanes and output register.
//
// Usage:
//   in_*  : one audio frame per transfer. in_tdata carries two signed Q1.23
//           samples, in_tuser the start-of-capture flag (clears the filter
//           history first), in_tlast the end-of-chunk flag.
//   out_* : one signed 16-bit PCM sample per frame, out_tlast copies the
//           end-of-chunk flag of that frame.
//   cfg_* : register writes (index 0 channel count, 1 gain, 2 filter
//           enable, 3 alpha); always ready, to be written while idle.
// Timing: the result passes through one step each for downmix, gain, filter
//   sum, alpha multiply (skipped with the filter bypassed), PCM scale and
//   rounding; one frame is in flight at a time, so a new frame is taken only
//   after the previous one has left the final step, which needs the output free.
//   The next frame is taken as soon as the sequencer is idle, even while the
//   previous result waits in the output register.
// Reset (synchronous, rst_n low): registers return to their defaults, the
//   filter history is zeroed and the output register is emptied.
// Stall: a full output register with out_tready low holds the sequencer in
//   its final step until the result is taken.
`default_nettype none
`include "mono_downmix_highpass_pcm16_core_macros.svh"
module mono_downmix_highpass_pcm16_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [2*mdhp_pkg::SAMPLE_W-1:0]   in_tdata,  // sample_ch0, sample_ch1
  input  wire logic                              in_tuser,  // start_of_capture
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [mdhp_pkg::PCM_W-1:0]             out_tdata, // pcm_sample
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mdhp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mdhp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mdhp_pkg::*;

  logic [CH_CNT_W-1:0] ch_cnt_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                hpf_en_r;
  logic [ALPHA_W-1:0]  alpha_r;

  state_t state_r;
  state_t state_nxt;
  ctrl_t  ctrl;

  logic                start_r;
  logic                last_r;
  logic                out_tvalid_r;
  pcm_t                out_pcm_r;
  logic                out_last_r;

  logic                in_xfer;
  logic                out_free;
  logic [CH_CNT_W-1:0] nch;
  logic                two_ch;
  sample_t             lanes [NUM_LANES];
  sample_t             mono;
  pcm_t                pcm;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r <= CH_CNT_RESET;
      gain_r   <= GAIN_RESET;
      hpf_en_r <= HPF_EN_RESET;
      alpha_r  <= ALPHA_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: ch_cnt_r <= cfg_data[CH_CNT_W-1:0];
        REG_INPUT_GAIN:    gain_r   <= cfg_data[GAIN_W-1:0];
        REG_HPF_ENABLE:    hpf_en_r <= cfg_data[0];
        REG_HPF_ALPHA:     alpha_r  <= cfg_data[ALPHA_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Active channel count: zero counts as one, then limit to the channel maximum and the lanes.
  always_comb begin
    nch = (ch_cnt_r == '0) ? CH_CNT_W'(1) : ch_cnt_r;
    if (nch > CH_CNT_W'(MAX_CHANNELS)) begin
      nch = CH_CNT_W'(MAX_CHANNELS);
    end
    if (nch > CH_CNT_W'(NUM_LANES)) begin
      nch = CH_CNT_W'(NUM_LANES);
    end
    two_ch = (nch == CH_CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_FILT;
      ST_FILT:  state_nxt = hpf_en_r ? ST_ALPHA : ST_SCALE;
      ST_ALPHA: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE:  in_tready  = 1'b1;
      ST_MIX:   ctrl.clear = start_r;
      ST_GAIN:  ctrl.gain  = 1'b1;
      ST_FILT:  ctrl.filt  = 1'b1;
      ST_ALPHA: ctrl.alpha = 1'b1;
      ST_SCALE: ctrl.scale = 1'b1;
      ST_ROUND: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      start_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    mdhp_lane u_lane (
      .clk    (clk),
      .load   (in_xfer),
      .active (CH_CNT_W'(i) < nch),
      .sample (in_tdata[i*SAMPLE_W +: SAMPLE_W]),
      .lane_q (lanes[i])
    );
  end

  mdhp_merge u_merge (
    .clk    (clk),
    .load   (state_r == ST_MIX),
    .two_ch (two_ch),
    .lanes  (lanes),
    .mono   (mono)
  );

  mdhp_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .hpf_en (hpf_en_r),
    .gain   (gain_r),
    .alpha  (alpha_r),
    .mono   (mono),
    .pcm    (pcm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_ROUND && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND && out_free) begin
      out_pcm_r  <= pcm;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pcm_r;
  assign out_tlast  = out_last_r;

  `MDHP_ASSERT_NEXT(a_accept_starts_mix, in_xfer, state_r == ST_MIX,
    "accepted frame did not enter the downmix step")
  `MDHP_ASSERT_NEXT(a_round_loads_output, (state_r == ST_ROUND) && out_free,
    out_tvalid_r && (state_r == ST_IDLE), "finished frame not moved to output")
  `MDHP_ASSERT_NEXT(a_round_holds_on_stall, (state_r == ST_ROUND) && !out_free,
    state_r == ST_ROUND, "sequencer left final step while output blocked")

endmodule
`default_nettype wire

>>> dv/mono_downmix_highpass_pcm16_core_tb.sv
// Self-checking testbench for the mono downmix high-pass PCM16 core.
module mono_downmix_highpass_pcm16_core_tb;
  import mdhp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(4);
  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;
  localparam pcm_t    P_MAX = 16'sd32767;
  localparam pcm_t    P_MIN = -16'sd32767;
  localparam longint  Q23_ONE = 64'sd8388608;
  localparam int RAND_PHASES    = 8;
  localparam int RAND_PER_PHASE = 240;
  localparam int HOLD_OFF       = 400;
  localparam int IDLE_LIMIT     = 3000;
  localparam int DRAIN_PAD      = 10;
  localparam int MAX_REPORTS    = 20;

  typedef struct packed {
    logic [15:0] chan;
    logic [15:0] gain;
    logic [15:0] en;
    logic [15:0] alpha;
  } regset_t;

  typedef struct packed {
    logic [2:0] setting;
    sample_t    ch0;
    sample_t    ch1;
    logic       start;
    logic       last;
    logic       typed;
    pcm_t       pcm;
  } probe_t;

  typedef struct {
    pcm_t pcm;
    logic last;
  } pcm_beat_t;

  // Setting 0 is the state after reset and is never written.
  localparam regset_t DIRECTED_SETS [6] = '{
    '{16'd1,     16'd4096,  16'd1,     16'd64772},
    '{16'd2,     16'd4096,  16'd0,     16'd64772},
    '{16'hFFFC,  16'hFFFF,  16'hFFFE,  16'd0},
    '{16'd3,     16'd0,     16'd1,     16'hFFFF},
    '{16'd1,     16'hFFFF,  16'd1,     16'hFFFF},
    '{16'd2,     16'd4096,  16'hFFFF,  16'd0}
  };

  localparam probe_t PROBES [22] = '{
    '{3'd0, 24'sd0,  24'sd0,  1'b1, 1'b0, 1'b1, 16'sd0},
    '{3'd0, S_MAX,   24'sd0,  1'b0, 1'b0, 1'b0, 16'sd0},
    '{3'd0, S_MIN,   S_MAX,   1'b0, 1'b0, 1'b0, 16'sd0},
    '{3'd0, 24'sd0,  24'sd0,  1'b0, 1'b1, 1'b0, 16'sd0},
    '{3'd0, 24'sd100000, -24'sd5, 1'b1, 1'b0, 1'b0, 16'sd0},
    '{3'd0, S_MIN,   S_MIN,   1'b0, 1'b1, 1'b0, 16'sd0},
    '{3'd1, S_MAX,   S_MAX,   1'b0, 1'b0, 1'b1, P_MAX},
    '{3'd1, S_MIN,   S_MIN,   1'b0, 1'b0, 1'b1, P_MIN},
    '{3'd1, S_MAX,   S_MIN,   1'b0, 1'b0, 1'b1, 16'sd0},
    '{3'd1, 24'sd1,  24'sd0,  1'b0, 1'b0, 1'b1, 16'sd0},
    '{3'd1, 24'sd0,  24'sd0,  1'b1, 1'b1, 1'b1, 16'sd0},
    '{3'd2, S_MAX,   S_MIN,   1'b0, 1'b0, 1'b1, P_MAX},
    '{3'd2, S_MIN,   S_MAX,   1'b0, 1'b0, 1'b1, P_MIN},
    '{3'd2, 24'sd1,  24'sd0,  1'b0, 1'b1, 1'b0, 16'sd0},
    '{3'd3, S_MAX,   S_MAX,   1'b1, 1'b0, 1'b1, 16'sd0},
    '{3'd3, S_MIN,   S_MIN,   1'b0, 1'b1, 1'b1, 16'sd0},
    '{3'd4, S_MAX,   24'sd0,  1'b1, 1'b0, 1'b0, 16'sd0},
    '{3'd4, S_MIN,   24'sd0,  1'b0, 1'b0, 1'b0, 16'sd0},
    '{3'd4, S_MAX,   24'sd0,  1'b0, 1'b0, 1'b0, 16'sd0},
    '{3'd4, 24'sd0,  24'sd0,  1'b0, 1'b1, 1'b0, 16'sd0},
    '{3'd5, S_MAX,   S_MAX,   1'b0, 1'b0, 1'b1, 16'sd0},
    '{3'd5, S_MIN,   S_MAX,   1'b0, 1'b1, 1'b1, 16'sd0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [2*SAMPLE_W-1:0]   in_tdata;   // sample_ch0, sample_ch1
  logic                    in_tuser;   // start_of_capture
  logic                    in_tlast;   // end_of_chunk
  logic                    out_tvalid;
  logic                    out_tready;
  logic [PCM_W-1:0]        out_tdata;  // pcm_sample
  logic                    out_tlast;  // chunk_last
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Register copy and filter history of the predictor
  int     chan_q;
  int     gain_q;
  int     en_q;
  int     alpha_q;
  longint hist_in;
  longint hist_out;

  pcm_beat_t pcm_due [$];
  int        frames_sent;
  int        pcm_checked;
  int        settings_used;
  int        mismatches;
  int        hold_req;
  bit        idle_on;

  mono_downmix_highpass_pcm16_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Downmix, gain, optional high-pass and PCM scaling of one frame
  function automatic pcm_t highpass_pcm(sample_t a, sample_t b, logic start);
    int     lanes;
    longint mono;
    longint gained;
    longint sum;
    longint y;
    longint v;
    lanes = (chan_q == 0) ? 1 : chan_q;
    if (lanes > MAX_CHANNELS) lanes = MAX_CHANNELS;
    if (lanes > NUM_LANES) lanes = NUM_LANES;
    if (start) begin
      hist_in  = 0;
      hist_out = 0;
    end
    mono   = (lanes == 2) ? ((longint'(a) + longint'(b)) >>> 1) : longint'(a);
    gained = (mono * gain_q + 2048) >>> 12;
    if (en_q != 0) begin
      sum      = sat32(hist_out + gained - hist_in);
      y        = sat32((sum * alpha_q + 32768) >>> 16);
      hist_in  = sat32(gained);
      hist_out = y;
      v        = y;
    end else begin
      v = gained;
    end
    if (v > Q23_ONE) v = Q23_ONE;
    if (v < -Q23_ONE) v = -Q23_ONE;
    return pcm_t'((v * 32767 + Q23_ONE / 2) >>> 23);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic sample_t draw_sample(int mode, sample_t prev);
    int v;
    v = 0;
    case (mode)
      0: v = int'(sample_t'($urandom));
      1: v = int'($urandom_range(131071)) - 65536;
      2: begin
        case ($urandom_range(4))
          0: v = 8388607;
          1: v = -8388608;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        // slow wander, so the high-pass has something to remove
        v = int'(prev) + int'($urandom_range(16383)) - 8192;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
      end
    endcase
    return sample_t'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH result %0d: %s", pcm_checked, what);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CHANNEL_COUNT: chan_q  = int'(data[CH_CNT_W-1:0]);
      REG_INPUT_GAIN:    gain_q  = int'(data[GAIN_W-1:0]);
      REG_HPF_ENABLE:    en_q    = int'(data[0]);
      REG_HPF_ALPHA:     alpha_q = int'(data[ALPHA_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic write_setting(input regset_t r);
    cfg_write(REG_CHANNEL_COUNT, r.chan);
    cfg_write(REG_INPUT_GAIN, r.gain);
    cfg_write(REG_HPF_ENABLE, r.en);
    cfg_write(REG_HPF_ALPHA, r.alpha);
    // writes past the register list must leave everything alone
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic push_frame(input sample_t a, input sample_t b, input logic start,
                            input logic last, input logic typed, input pcm_t typed_pcm);
    pcm_t pcm;
    in_tdata  <= {b, a};
    in_tuser  <= start;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // the predictor runs on every frame so its history stays in step
    pcm = highpass_pcm(a, b, start);
    pcm_due.push_back('{typed ? typed_pcm : pcm, last});
    frames_sent++;
  endtask

  // Hold the input back until every result is in and the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pcm_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin : stimulus
    int      cur;
    int      k;
    int      j;
    int      cap_len;
    int      chunk;
    int      mode;
    int      g;
    sample_t a;
    sample_t b;
    logic    start;
    logic    last;
    regset_t r;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    chan_q   = int'(CH_CNT_RESET);
    gain_q   = int'(GAIN_RESET);
    en_q     = int'(HPF_EN_RESET);
    alpha_q  = int'(ALPHA_RESET);
    hist_in  = 0;
    hist_out = 0;
    hold_req = 0;
    idle_on  = 1'b0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = 0;
    for (int i = 0; i < $size(PROBES); i++) begin
      if (int'(PROBES[i].setting) != cur) begin
        drain();
        cur = int'(PROBES[i].setting);
        write_setting(DIRECTED_SETS[cur]);
      end
      push_frame(PROBES[i].ch0, PROBES[i].ch1, PROBES[i].start, PROBES[i].last,
                 PROBES[i].typed, PROBES[i].pcm);
    end

    a = '0;
    b = '0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      r.chan = (CFG_DATA_W'($urandom) & 16'hFFFC) | CFG_DATA_W'(p % 4);
      case ($urandom_range(4))
        0: r.gain = 16'd0;
        1: r.gain = 16'hFFFF;
        2: r.gain = 16'd4096;
        3: r.gain = CFG_DATA_W'($urandom_range(16384));
        default: r.gain = CFG_DATA_W'($urandom);
      endcase
      r.en = CFG_DATA_W'($urandom);
      case ($urandom_range(3))
        0: r.alpha = 16'd0;
        1: r.alpha = 16'hFFFF;
        2: r.alpha = CFG_DATA_W'($urandom_range(65535, 60000));
        default: r.alpha = CFG_DATA_W'($urandom);
      endcase
      write_setting(r);
      idle_on = (p % 3) != 0;
      if (p == 2) hold_req = HOLD_OFF;

      k = 0;
      while (k < RAND_PER_PHASE) begin
        cap_len = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : $urandom_range(120, 20);
        chunk   = $urandom_range(16, 1);
        mode    = $urandom_range(3);
        for (j = 0; j < cap_len && k < RAND_PER_PHASE; j++) begin
          start = (j == 0);
          last  = ((j + 1) % chunk == 0) || (j == cap_len - 1);
          // stray flags mid-capture
          if ($urandom_range(39) == 0) start = ~start;
          if ($urandom_range(39) == 0) last = ~last;
          a = draw_sample(mode, a);
          b = draw_sample(mode, b);
          push_frame(a, b, start, last, 1'b0, '0);
          k++;
          g = idle_on ? pick_gap() : 0;
          if (g > 0) begin
            in_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
          end
        end
      end
    end
    drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d PCM results from %0d frames across %0d register settings.",
             pcm_checked, frames_sent, settings_used);
    $display("Mono and stereo downmix, filter on and off, capture restarts, output hold-off.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : sink
    int        stall_left;
    pcm_beat_t want;
    stall_left = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pcm_due.size() == 0) begin
          report_mismatch($sformatf("unexpected pcm %0d", $signed(out_tdata)));
        end else begin
          want = pcm_due.pop_front();
          pcm_checked++;
          if (out_tdata !== want.pcm)
            report_mismatch($sformatf("pcm %0d, want %0d", $signed(out_tdata), want.pcm));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("chunk_last %b, want %b", out_tlast, want.last));
        end
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end else if (stall_left == 0) begin
        stall_left = idle_on ? pick_gap() : 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
